### rtl/core/rai_pkg.sv
// types and constants for the ray / annulus intersection core
// no dependencies

package rai_pkg;

    localparam int DATA_W   = 32;
    localparam int ROW_W    = 48;
    localparam int TERM_W   = 16;
    localparam int HOLE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int QUO_W    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE   = 3'd6;

    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h0000_0000_1000;

    localparam logic signed [DATA_W-1:0] MISS_DIST = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] ox;
        logic signed [DATA_W-1:0] oy;
        logic signed [DATA_W-1:0] dx;
        logic signed [DATA_W-1:0] dy;
        logic signed [DATA_W-1:0] t_min;
        logic signed [DATA_W-1:0] t_max;
        logic                     active;
        logic                     dz_zero;
        logic                     t_neg;
    } t_side;

endpackage

### rtl/core/ray_annulus_intersect.sv
// ray against annulus in the object z=0 plane, fully pipelined
// depends on rai_pkg
//
// channel  | handshake                  | payload
// ray in   | start, busy                | i_origin_*, i_dir_*, i_t_min, i_t_max, i_ray_active
// result   | o_valid (strobe)           | o_hit, o_hit_distance, o_local_x, o_local_y
// config   | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one ray per cycle; the 48-stage radix-2 divider for t sits between the
// transform stages before it and the hit-test stages after it
// busy stays low, config is always ready; synchronous active-low reset clears
// valid bits and loads the identity transform with no hole
// results leave as one-cycle strobes; there is no stall path

module ray_annulus_intersect #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rai_pkg::DATA_W-1:0] i_origin_x,
    input  logic signed [rai_pkg::DATA_W-1:0] i_origin_y,
    input  logic signed [rai_pkg::DATA_W-1:0] i_origin_z,
    input  logic signed [rai_pkg::DATA_W-1:0] i_dir_x,
    input  logic signed [rai_pkg::DATA_W-1:0] i_dir_y,
    input  logic signed [rai_pkg::DATA_W-1:0] i_dir_z,
    input  logic signed [rai_pkg::DATA_W-1:0] i_t_min,
    input  logic signed [rai_pkg::DATA_W-1:0] i_t_max,
    input  logic                              i_ray_active,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [rai_pkg::DATA_W-1:0] o_hit_distance,
    output logic signed [rai_pkg::DATA_W-1:0] o_local_x,
    output logic signed [rai_pkg::DATA_W-1:0] o_local_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rai_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rai_pkg::ROW_W-1:0]         i_cfg_data
);
    import rai_pkg::*;

    localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam int PROD_W = TERM_W + DATA_W;
    localparam int LAT = 3 + QUO_W + 6;

    function automatic logic signed [DATA_W-1:0] sat_cw(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            if (v > SAT_HI) begin
                r = SAT_HI;
            end else if (v < SAT_LO) begin
                r = SAT_LO;
            end else begin
                r = v;
            end
            return r[DATA_W-1:0];
        end
    endfunction

    // configuration
    logic [ROW_W-1:0]         r_row [3];
    logic signed [DATA_W-1:0] r_ofs [3];
    logic [HOLE_W-1:0]        r_hole;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_X_RST;
            r_row[1] <= ROW_Y_RST;
            r_row[2] <= ROW_Z_RST;
            r_ofs[0] <= '0;
            r_ofs[1] <= '0;
            r_ofs[2] <= '0;
            r_hole   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ROW_X: r_row[0] <= i_cfg_data;
                REG_ROW_Y: r_row[1] <= i_cfg_data;
                REG_ROW_Z: r_row[2] <= i_cfg_data;
                REG_OFS_X: r_ofs[0] <= i_cfg_data[DATA_W-1:0];
                REG_OFS_Y: r_ofs[1] <= i_cfg_data[DATA_W-1:0];
                REG_OFS_Z: r_ofs[2] <= i_cfg_data[DATA_W-1:0];
                REG_HOLE:  r_hole   <= i_cfg_data[HOLE_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    // stage a: matrix products
    logic signed [PROD_W-1:0] r_po [3][3];
    logic signed [PROD_W-1:0] r_pd [3][3];
    logic signed [DATA_W-1:0] r_a_tmin, r_a_tmax;
    logic                     r_a_act;
    logic signed [DATA_W-1:0] n_w [3];
    logic signed [DATA_W-1:0] n_v [3];

    assign n_w[0] = i_origin_x;
    assign n_w[1] = i_origin_y;
    assign n_w[2] = i_origin_z;
    assign n_v[0] = i_dir_x;
    assign n_v[1] = i_dir_y;
    assign n_v[2] = i_dir_z;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_po[r][c] <= PROD_W'($signed(r_row[r][ROW_W-1-TERM_W*c -: TERM_W]) * n_w[c]);
                r_pd[r][c] <= PROD_W'($signed(r_row[r][ROW_W-1-TERM_W*c -: TERM_W]) * n_v[c]);
            end
        end
        r_a_tmin <= i_t_min;
        r_a_tmax <= i_t_max;
        r_a_act  <= i_ray_active;
    end

    // stage b: sum, floor shift, offset, saturate
    logic signed [DATA_W-1:0] r_o [3];
    logic signed [DATA_W-1:0] r_d [3];
    logic signed [DATA_W-1:0] r_b_tmin, r_b_tmax;
    logic                     r_b_act;

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_o[r] <= sat_cw((64'((PROD_W + 2)'(r_po[r][0]) + (PROD_W + 2)'(r_po[r][1])
                           + (PROD_W + 2)'(r_po[r][2])) >>> 12) + 64'(r_ofs[r]));
            r_d[r] <= sat_cw(64'((PROD_W + 2)'(r_pd[r][0]) + (PROD_W + 2)'(r_pd[r][1])
                           + (PROD_W + 2)'(r_pd[r][2])) >>> 12);
        end
        r_b_tmin <= r_a_tmin;
        r_b_tmax <= r_a_tmax;
        r_b_act  <= r_a_act;
    end

    // stage c: divider operands as magnitudes
    logic [DATA_W:0]    r_rem [QUO_W+1];
    logic [QUO_W-1:0]   r_nq  [QUO_W+1];
    logic [DATA_W-1:0]  r_den [QUO_W+1];
    t_side              r_sd  [QUO_W+1];
    logic [DATA_W-1:0]  n_oz_mag, n_dz_mag;
    logic               n_dz_zero;

    assign n_oz_mag  = r_o[2][DATA_W-1] ? DATA_W'(-r_o[2]) : DATA_W'(r_o[2]);
    assign n_dz_mag  = r_d[2][DATA_W-1] ? DATA_W'(-r_d[2]) : DATA_W'(r_d[2]);
    assign n_dz_zero = (r_d[2] == '0);

    always_ff @(posedge i_clk) begin
        r_rem[0]          <= '0;
        r_nq[0]           <= {n_oz_mag, 16'b0};
        r_den[0]          <= n_dz_zero ? DATA_W'(1) : n_dz_mag;
        r_sd[0].ox        <= r_o[0];
        r_sd[0].oy        <= r_o[1];
        r_sd[0].dx        <= r_d[0];
        r_sd[0].dy        <= r_d[1];
        r_sd[0].t_min     <= r_b_tmin;
        r_sd[0].t_max     <= r_b_tmax;
        r_sd[0].active    <= r_b_act;
        r_sd[0].dz_zero   <= n_dz_zero;
        // -oz / dz is negative when oz and dz have the same sign
        r_sd[0].t_neg     <= (r_o[2] > 0) ^ r_d[2][DATA_W-1];
    end

    // radix-2 restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [DATA_W:0] n_sh, n_sub;
        assign n_sh  = {r_rem[k][DATA_W-1:0], r_nq[k][QUO_W-1]};
        assign n_sub = n_sh - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (n_sh >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= n_sub;
                r_nq[k+1]  <= {r_nq[k][QUO_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_sh;
                r_nq[k+1]  <= {r_nq[k][QUO_W-2:0], 1'b0};
            end
            r_den[k+1] <= r_den[k];
            r_sd[k+1]  <= r_sd[k];
        end
    end

    // e1: signed t
    logic signed [QUO_W:0] r_e1_t;
    t_side                 r_e1_sd;
    always_ff @(posedge i_clk) begin
        r_e1_t  <= r_sd[QUO_W].t_neg ? -$signed({1'b0, r_nq[QUO_W]})
                                     : $signed({1'b0, r_nq[QUO_W]});
        r_e1_sd <= r_sd[QUO_W];
    end

    // e2: segment test and saturated t
    logic                     r_e2_in;
    logic signed [DATA_W-1:0] r_e2_tsat, r_e2_t;
    t_side                    r_e2_sd;
    always_ff @(posedge i_clk) begin
        r_e2_in   <= (r_e1_t >= (QUO_W + 1)'(r_e1_sd.t_min))
                  && (r_e1_t <= (QUO_W + 1)'(r_e1_sd.t_max));
        r_e2_tsat <= sat_cw(64'(r_e1_t));
        r_e2_t    <= r_e1_t[DATA_W-1:0];
        r_e2_sd   <= r_e1_sd;
    end

    // e3: direction times t
    logic signed [2*DATA_W-1:0] r_e3_px, r_e3_py;
    logic                       r_e3_in;
    logic signed [DATA_W-1:0]   r_e3_t;
    t_side                      r_e3_sd;
    always_ff @(posedge i_clk) begin
        r_e3_px <= r_e2_sd.dx * r_e2_tsat;
        r_e3_py <= r_e2_sd.dy * r_e2_tsat;
        r_e3_in <= r_e2_in;
        r_e3_t  <= r_e2_t;
        r_e3_sd <= r_e2_sd;
    end

    // e4: plane point
    logic signed [DATA_W-1:0] r_e4_lx, r_e4_ly, r_e4_t;
    logic                     r_e4_ok;
    always_ff @(posedge i_clk) begin
        if (r_e3_sd.dz_zero) begin
            r_e4_lx <= '0;
            r_e4_ly <= '0;
        end else begin
            r_e4_lx <= sat_cw(64'(r_e3_sd.ox) + (r_e3_px >>> 16));
            r_e4_ly <= sat_cw(64'(r_e3_sd.oy) + (r_e3_py >>> 16));
        end
        r_e4_ok <= r_e3_in && r_e3_sd.active && !r_e3_sd.dz_zero;
        r_e4_t  <= r_e3_t;
    end

    // e5: squares
    logic [2*DATA_W-1:0]      r_e5_sx, r_e5_sy;
    logic signed [DATA_W-1:0] r_e5_lx, r_e5_ly, r_e5_t;
    logic                     r_e5_ok;
    logic [DATA_W-1:0]        n_ax, n_ay;
    assign n_ax = r_e4_lx[DATA_W-1] ? DATA_W'(-r_e4_lx) : DATA_W'(r_e4_lx);
    assign n_ay = r_e4_ly[DATA_W-1] ? DATA_W'(-r_e4_ly) : DATA_W'(r_e4_ly);
    always_ff @(posedge i_clk) begin
        r_e5_sx <= n_ax * n_ax;
        r_e5_sy <= n_ay * n_ay;
        r_e5_lx <= r_e4_lx;
        r_e5_ly <= r_e4_ly;
        r_e5_t  <= r_e4_t;
        r_e5_ok <= r_e4_ok;
    end

    // e6: radius test and output beat
    logic [2*DATA_W:0] n_r2;
    logic              n_hit;
    assign n_r2  = {1'b0, r_e5_sx} + {1'b0, r_e5_sy};
    assign n_hit = r_e5_ok && (n_r2 <= (2*DATA_W + 1)'(64'h1_0000_0000))
                && (n_r2 > (2*DATA_W + 1)'({r_hole, 16'b0}));

    logic                     r_hit;
    logic signed [DATA_W-1:0] r_dist, r_lx, r_ly;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= r_vld[LAT-2] && n_hit;
        end
        r_dist <= n_hit ? r_e5_t : MISS_DIST;
        r_lx   <= r_e5_lx;
        r_ly   <= r_e5_ly;
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;
    assign o_local_x      = r_lx;
    assign o_local_y      = r_ly;

    a_hit_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid) else $error("hit without result strobe");

    a_miss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_distance == MISS_DIST)
        else $error("miss without saturated distance");

    a_hit_off_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (o_local_x != 0 || o_local_y != 0))
        else $error("hit at the center of the annulus");

    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> $past(start)) else $error("beat entered without start");

endmodule
